[sv/ebrq_pkg.sv]
// Shared types and constants for the escaped byte ring queue.
// Holds the transfer payload structs, operation codes and default parameter values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ebrq_pkg;

	localparam int unsigned DEPTH_DEF   = 512;
	localparam int unsigned RESERVE_DEF = 64;
	localparam int unsigned MARKER_DEF  = 1;

	localparam logic [7:0] ESC_BYTE = 8'hE9;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_PEEK  = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [8:0] data_value;
		logic       suppress_repeat;
	} ebrq_in_t;

	typedef struct packed {
		logic       status;
		logic [8:0] read_data;
	} ebrq_out_t;

endpackage
`default_nettype wire

[sv/ebrq_mem.sv]
// Byte store of the escaped byte ring queue: one write port and one registered read port.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none
module ebrq_mem #(
	parameter int unsigned DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [7:0]               wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [7:0]               rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

[sv/escaped_byte_ring_queue.sv]
// Top level of the escaped byte ring queue: sequencer, pointers and result buffering.
// Depends on ebrq_pkg and ebrq_mem.
// Plain operations finish in the execute state; escaped reads and writes need a second
// state (RD2 or WR2), and a repeat-suppression check may pass through SUP2 first.
// A new item is taken only in the idle state with the pending result slot empty, so one
// item is handled at a time; the byte store has a single read and a single write port.
// Reset clears both pointers and disables escaping; the store itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module escaped_byte_ring_queue #(
	parameter int unsigned DEPTH       = ebrq_pkg::DEPTH_DEF,
	parameter int unsigned RESERVE     = ebrq_pkg::RESERVE_DEF,
	parameter int unsigned MARKER_BYTE = ebrq_pkg::MARKER_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ebrq_pkg::ebrq_in_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ebrq_pkg::ebrq_out_t     out_data
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [PW:0] DEPTH_X = (PW+1)'(DEPTH);
	localparam logic [PW:0] RESERVE_X = (PW+1)'(RESERVE);
	localparam logic [7:0] MARKER = 8'(MARKER_BYTE);
	localparam logic [8:0] ESC_DATA = {1'b0, ebrq_pkg::ESC_BYTE};

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_SUP2 = 5'b00100,
		ST_WR2  = 5'b01000,
		ST_RD2  = 5'b10000
	} state_t;

	state_t              state_q, state_d;
	logic [PW-1:0]       wp_q, wp_d, rp_q, rp_d;
	logic                esc_q;
	ebrq_pkg::ebrq_in_t  item_q;
	ebrq_pkg::ebrq_out_t pend_q, out_q, fin_res;
	logic                pend_valid_q, out_valid_q, out_free;
	logic                in_xfer;

	logic                mem_we;
	logic [PW-1:0]       mem_waddr, mem_raddr;
	logic [7:0]          mem_wdata, mem_rdata;

	logic [PW-1:0]       p1, p2, nh, n2, rn1, rn2;
	logic [PW:0]         free_raw, free_slots;
	logic                in_reserve, needs_esc, is_wr, is_rd, empty;
	logic                fin, do_wr;
	logic [8:0]          cval;

	function automatic logic [PW-1:0] next_idx(input logic [PW-1:0] p);
		return (p == LAST_IDX) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] prev_idx(input logic [PW-1:0] p);
		return (p == '0) ? LAST_IDX : p - PW'(1);
	endfunction

	assign in_xfer  = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && !pend_valid_q;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cval  = item_q.data_value;
	assign is_wr = item_q.func == ebrq_pkg::FUNC_WRITE;
	assign is_rd = (item_q.func == ebrq_pkg::FUNC_READ) || (item_q.func == ebrq_pkg::FUNC_PEEK);
	assign empty = wp_q == rp_q;

	assign p1  = prev_idx(wp_q);
	assign p2  = prev_idx(p1);
	assign nh  = next_idx(wp_q);
	assign n2  = next_idx(nh);
	assign rn1 = next_idx(rp_q);
	assign rn2 = next_idx(rn1);

	assign free_raw   = {1'b0, rp_q} + DEPTH_X - {1'b0, wp_q} - (PW+1)'(1);
	assign free_slots = (free_raw >= DEPTH_X) ? free_raw - DEPTH_X : free_raw;
	assign in_reserve = free_slots <= RESERVE_X;
	assign needs_esc  = esc_q && (cval[8] || (cval == ESC_DATA));

	always_comb begin
		case (state_q)
			ST_IDLE: mem_raddr = (in_data.func == ebrq_pkg::FUNC_WRITE) ? p1 : rp_q;
			ST_EXEC: mem_raddr = is_wr ? p2 : rn1;
			default: mem_raddr = rp_q;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		wp_d      = wp_q;
		rp_d      = rp_q;
		mem_we    = 1'b0;
		mem_waddr = wp_q;
		mem_wdata = cval[7:0];
		fin       = 1'b0;
		fin_res   = '{status: 1'b1, read_data: 9'd0};
		do_wr     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (is_wr) begin
					if (esc_q && !cval[8] && in_reserve) begin
						fin = 1'b1;
					end else if (esc_q && cval[8] && item_q.suppress_repeat && !empty) begin
						if ((mem_rdata == cval[7:0]) && (p1 != rp_q)) begin
							state_d = ST_SUP2;
						end else begin
							do_wr = 1'b1;
						end
					end else begin
						do_wr = 1'b1;
					end
				end else if (is_rd) begin
					if (empty) begin
						fin = 1'b1;
					end else if (esc_q && (mem_rdata == ebrq_pkg::ESC_BYTE)) begin
						if (rn1 == wp_q) begin
							fin = 1'b1;
						end else begin
							state_d = ST_RD2;
						end
					end else begin
						fin = 1'b1;
						fin_res = '{status: 1'b0, read_data: {1'b0, mem_rdata}};
						if (item_q.func == ebrq_pkg::FUNC_READ) begin
							rp_d = rn1;
						end
					end
				end else begin
					fin = 1'b1;
				end
			end
			ST_SUP2: begin
				if (mem_rdata == ebrq_pkg::ESC_BYTE) begin
					fin = 1'b1;
					fin_res.status = 1'b0;
				end else begin
					do_wr = 1'b1;
				end
			end
			ST_WR2: begin
				mem_we    = 1'b1;
				mem_waddr = nh;
				mem_wdata = (cval == ESC_DATA) ? MARKER : cval[7:0];
				wp_d      = n2;
				fin       = 1'b1;
				fin_res.status = 1'b0;
			end
			ST_RD2: begin
				fin = 1'b1;
				fin_res = '{status: 1'b0,
					read_data: (mem_rdata != MARKER) ? {1'b1, mem_rdata} : ESC_DATA};
				if (item_q.func == ebrq_pkg::FUNC_READ) begin
					rp_d = rn2;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (do_wr) begin
			if (nh == rp_q) begin
				fin = 1'b1;
			end else if (needs_esc) begin
				if (n2 == rp_q) begin
					fin = 1'b1;
				end else begin
					mem_we    = 1'b1;
					mem_wdata = ebrq_pkg::ESC_BYTE;
					state_d   = ST_WR2;
				end
			end else begin
				mem_we = 1'b1;
				wp_d   = nh;
				fin    = 1'b1;
				fin_res.status = 1'b0;
			end
		end
		if (fin) begin
			state_d = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wp_q         <= '0;
			rp_q         <= '0;
			esc_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			if (cfg_we) begin
				esc_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pend_valid_q && out_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end
			if (fin) begin
				if (out_free && !pend_valid_q) begin
					out_valid_q <= 1'b1;
				end else begin
					pend_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_q <= in_data;
		end
		if (pend_valid_q && out_free) begin
			out_q <= pend_q;
		end
		if (fin) begin
			if (out_free && !pend_valid_q) begin
				out_q <= fin_res;
			end else begin
				pend_q <= fin_res;
			end
		end
	end

	ebrq_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_addr(mem_raddr),
		.rd_data(mem_rdata)
	);

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, wp_q} < DEPTH_X) && ({1'b0, rp_q} < DEPTH_X))
		else $error("Queue pointer outside the store.");

	a_pend_free: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !pend_valid_q)
		else $error("Result completed while the pending slot is still full.");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == ST_EXEC) || (state_q == ST_SUP2) || (state_q == ST_WR2)))
		else $error("Store written outside a write step.");

	a_wr2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR2) |=> (wp_q != $past(wp_q)))
		else $error("Escaped write did not advance the write pointer.");

endmodule
`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the escaped byte ring queue: directed and random transfers.
// Each result is checked against a cycle-free software copy of the queue held in this file.
// Depends on ebrq_pkg and escaped_byte_ring_queue.
`timescale 1ns / 1ps
module testbench;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned CTRL_BASE = 256;
	localparam int unsigned AW = $clog2(ebrq_pkg::DEPTH_DEF);

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic                cfg_wdata = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	ebrq_pkg::ebrq_in_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	ebrq_pkg::ebrq_out_t out_data;

	escaped_byte_ring_queue #(
		.DEPTH(ebrq_pkg::DEPTH_DEF),
		.RESERVE(ebrq_pkg::RESERVE_DEF),
		.MARKER_BYTE(ebrq_pkg::MARKER_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	// Software copy of the queue.
	logic [7:0]  fifo_mem [ebrq_pkg::DEPTH_DEF];
	int unsigned wr_idx = 0;
	int unsigned rd_idx = 0;
	logic        esc_on = 1'b0;
	int unsigned peak_fill = 0;

	ebrq_pkg::ebrq_in_t  stimulus_items [$];
	ebrq_pkg::ebrq_out_t expected_responses [$];

	int unsigned         errors = 0;
	int unsigned         n_accepted = 0;
	int unsigned         n_checked = 0;
	int unsigned         n_blocked = 0;
	int unsigned         n_ctrl_read = 0;
	logic                in_fire = 1'b0;
	ebrq_pkg::ebrq_out_t want;

	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	logic [15:0] stall_pat = 16'hFFFF;
	int unsigned stall_count = 0;
	logic [8:0]  last_ctrl = 9'd256;

	function automatic int unsigned nxt(int unsigned p);
		return (p + 1 >= ebrq_pkg::DEPTH_DEF) ? 0 : p + 1;
	endfunction

	function automatic int unsigned prv(int unsigned p);
		return (p == 0) ? ebrq_pkg::DEPTH_DEF - 1 : p - 1;
	endfunction

	function automatic int unsigned free_count();
		int unsigned s;
		s = rd_idx + ebrq_pkg::DEPTH_DEF - wr_idx - 1;
		if (s >= ebrq_pkg::DEPTH_DEF) s -= ebrq_pkg::DEPTH_DEF;
		return s;
	endfunction

	function automatic logic store_value(logic [8:0] v, logic sup);
		int unsigned nh;
		int unsigned n2;
		int unsigned p;
		if (esc_on) begin
			if (!v[8]) begin
				if (free_count() <= ebrq_pkg::RESERVE_DEF) return 1'b1;
			end else if (sup && wr_idx != rd_idx) begin
				p = prv(wr_idx);
				if (fifo_mem[AW'(p)] == v[7:0] && p != rd_idx) begin
					p = prv(p);
					if (fifo_mem[AW'(p)] == ebrq_pkg::ESC_BYTE) return 1'b0;
				end
			end
		end
		nh = nxt(wr_idx);
		if (nh == rd_idx) return 1'b1;
		if (esc_on && (v[8] || v == {1'b0, ebrq_pkg::ESC_BYTE})) begin
			n2 = nxt(nh);
			if (n2 == rd_idx) return 1'b1;
			fifo_mem[AW'(wr_idx)] = ebrq_pkg::ESC_BYTE;
			fifo_mem[AW'(nh)] = v[8] ? v[7:0] : ebrq_pkg::MARKER_DEF[7:0];
			wr_idx = n2;
			return 1'b0;
		end
		fifo_mem[AW'(wr_idx)] = v[7:0];
		wr_idx = nh;
		return 1'b0;
	endfunction

	function automatic ebrq_pkg::ebrq_out_t fetch_value(logic remove);
		ebrq_pkg::ebrq_out_t r;
		int unsigned         t;
		logic [8:0]          cc;
		logic [7:0]          nc;
		r = '0;
		t = rd_idx;
		if (t == wr_idx) begin
			r.status = 1'b1;
			return r;
		end
		cc = {1'b0, fifo_mem[AW'(t)]};
		t = nxt(t);
		if (esc_on && cc[7:0] == ebrq_pkg::ESC_BYTE) begin
			if (t == wr_idx) begin
				r.status = 1'b1;
				return r;
			end
			nc = fifo_mem[AW'(t)];
			if (nc != ebrq_pkg::MARKER_DEF[7:0]) cc = {1'b1, nc};
			t = nxt(t);
		end
		r.read_data = cc;
		if (remove) rd_idx = t;
		return r;
	endfunction

	function automatic ebrq_pkg::ebrq_out_t predict_response(ebrq_pkg::ebrq_in_t it);
		ebrq_pkg::ebrq_out_t r;
		int unsigned         fill;
		r = '0;
		case (it.func)
			ebrq_pkg::FUNC_WRITE: r.status = store_value(it.data_value, it.suppress_repeat);
			ebrq_pkg::FUNC_READ:  r = fetch_value(1'b1);
			ebrq_pkg::FUNC_PEEK:  r = fetch_value(1'b0);
			default:              r.status = 1'b1;
		endcase
		fill = ebrq_pkg::DEPTH_DEF - 1 - free_count();
		if (fill > peak_fill) peak_fill = fill;
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
		$display("MISMATCH at %0t: %s, got %0d, expected %0d", $time, what, got, exp_val);
		errors++;
	endtask

	// Monitor: predicts on each input transfer and checks each output transfer.
	always @(posedge clk) begin
		in_fire = 1'b0;
		if (arst_n) begin
			if (cfg_we) esc_on = cfg_wdata;
			if (in_valid && in_ready) begin
				in_fire = 1'b1;
				n_accepted++;
				expected_responses.push_back(predict_response(in_data));
			end
			if (out_valid && out_ready) begin
				if (expected_responses.size() == 0) begin
					report_mismatch("response with nothing outstanding", 32'(out_data), 0);
				end else begin
					want = expected_responses.pop_front();
					n_checked++;
					if (want.status) n_blocked++;
					if (!want.status && want.read_data[8]) n_ctrl_read++;
					if (out_data.status !== want.status)
						report_mismatch("status", 32'(out_data.status), 32'(want.status));
					if (out_data.read_data !== want.read_data)
						report_mismatch("read_data", 32'(out_data.read_data),
							32'(want.read_data));
				end
			end
		end
	end

	// Driver: bursts of items separated by random gaps.
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (stimulus_items.size() > 0) begin
				in_data <= stimulus_items.pop_front();
				in_valid <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: rotating stall pattern, replaced at random with a new one.
	always @(negedge clk) begin
		if (stall_count == 0) begin
			stall_count = $urandom_range(16, 80);
			case ($urandom_range(0, 3))
				0: stall_pat = 16'hFFFF;
				1: stall_pat = 16'($urandom);
				2: stall_pat = 16'($urandom | $urandom);
				default: stall_pat = 16'hFFFF ^ (16'h1 << $urandom_range(0, 15));
			endcase
		end else begin
			stall_count--;
		end
		stall_pat = {stall_pat[0], stall_pat[15:1]};
		out_ready <= stall_pat[0] | ~arst_n;
	end

	task automatic add_item(logic [1:0] f, logic [8:0] v, logic sup);
		ebrq_pkg::ebrq_in_t it;
		it.func = f;
		it.data_value = v;
		it.suppress_repeat = sup;
		stimulus_items.push_back(it);
	endtask

	task automatic write_escape(logic v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		int unsigned n;
		n = 0;
		while ((stimulus_items.size() != 0 || in_valid || expected_responses.size() != 0)
				&& n < 200000) begin
			@(posedge clk);
			#1;
			n++;
		end
		repeat (6) @(posedge clk);
	endtask

	function automatic ebrq_pkg::ebrq_in_t random_item(int unsigned write_pct);
		ebrq_pkg::ebrq_in_t it;
		int unsigned        r;
		it.suppress_repeat = 1'($urandom_range(0, 1));
		it.data_value = 9'($urandom_range(0, 511));
		r = $urandom_range(0, 99);
		if (r < write_pct) begin
			it.func = ebrq_pkg::FUNC_WRITE;
			r = $urandom_range(0, 99);
			if (r < 15) begin
				it.data_value = last_ctrl;
			end else if (r < 35) begin
				case ($urandom_range(0, 4))
					0: it.data_value = 9'd256;
					1: it.data_value = 9'(9'd256 + ebrq_pkg::MARKER_DEF);
					2: it.data_value = 9'd300;
					3: it.data_value = 9'd511;
					default: it.data_value = {1'b1, ebrq_pkg::ESC_BYTE};
				endcase
			end else if (r < 45) begin
				it.data_value = {1'b0, ebrq_pkg::ESC_BYTE};
			end else if (r < 65) begin
				it.data_value = 9'($urandom_range(0, 255));
			end
			if (it.data_value >= CTRL_BASE) last_ctrl = it.data_value;
		end else if (r >= 98) begin
			it.func = FUNC_UNUSED;
		end else begin
			it.func = ($urandom_range(0, 2) == 0) ? ebrq_pkg::FUNC_PEEK : ebrq_pkg::FUNC_READ;
		end
		return it;
	endfunction

	task automatic run_phase(logic esc, int unsigned write_pct, int unsigned count);
		write_escape(esc);
		repeat (count) stimulus_items.push_back(random_item(write_pct));
		wait_idle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Plain mode: empty queue answers, unused code, and a byte that later looks like an escape.
		write_escape(1'b0);
		add_item(ebrq_pkg::FUNC_READ, 9'd0, 1'b0);
		add_item(ebrq_pkg::FUNC_PEEK, 9'd0, 1'b0);
		add_item(FUNC_UNUSED, 9'd511, 1'b1);
		add_item(ebrq_pkg::FUNC_WRITE, {1'b1, ebrq_pkg::ESC_BYTE}, 1'b0);
		wait_idle();

		// Escaping on: lone escape, field extremes, marker collision and repeat suppression.
		write_escape(1'b1);
		add_item(ebrq_pkg::FUNC_PEEK, 9'd0, 1'b0);
		add_item(ebrq_pkg::FUNC_READ, 9'd0, 1'b0);
		add_item(ebrq_pkg::FUNC_WRITE, 9'd5, 1'b0);
		add_item(ebrq_pkg::FUNC_READ, 9'd0, 1'b0);
		add_item(ebrq_pkg::FUNC_READ, 9'd0, 1'b0);
		add_item(ebrq_pkg::FUNC_WRITE, 9'd0, 1'b0);
		add_item(ebrq_pkg::FUNC_WRITE, 9'd255, 1'b0);
		add_item(ebrq_pkg::FUNC_WRITE, {1'b0, ebrq_pkg::ESC_BYTE}, 1'b0);
		add_item(ebrq_pkg::FUNC_WRITE, 9'd256, 1'b0);
		add_item(ebrq_pkg::FUNC_WRITE, 9'd511, 1'b0);
		add_item(ebrq_pkg::FUNC_WRITE, 9'(9'd256 + ebrq_pkg::MARKER_DEF), 1'b0);
		add_item(ebrq_pkg::FUNC_WRITE, 9'd300, 1'b1);
		add_item(ebrq_pkg::FUNC_WRITE, 9'd300, 1'b1);
		add_item(ebrq_pkg::FUNC_WRITE, 9'd301, 1'b1);
		add_item(ebrq_pkg::FUNC_WRITE, 9'd0, 1'b1);
		add_item(ebrq_pkg::FUNC_PEEK, 9'd0, 1'b0);
		repeat (8) add_item(ebrq_pkg::FUNC_READ, 9'd0, 1'b0);
		add_item(ebrq_pkg::FUNC_READ, 9'd0, 1'b0);
		wait_idle();

		run_phase(1'b1, 90, 200);
		run_phase(1'b1, 85, 200);
		run_phase(1'b1, 50, 150);
		run_phase(1'b0, 15, 200);
		run_phase(1'b0, 90, 250);
		run_phase(1'b1, 20, 200);
		run_phase(1'b1, 60, 150);
		run_phase(1'b0, 50, 50);

		repeat (10) @(posedge clk);
		if (expected_responses.size() != 0)
			report_mismatch("responses never delivered", 0, expected_responses.size());
		$display("Checked %0d responses for %0d input transfers; %0d would-block answers.",
			n_checked, n_accepted, n_blocked);
		$display("Control codes read back: %0d; peak queue fill: %0d of %0d bytes.",
			n_ctrl_read, peak_fill, ebrq_pkg::DEPTH_DEF - 1);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("Timeout: run did not finish in the allowed time.");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
